// ===== hdl/dynamic_partition_allocator_assert.svh =====
// assertion macros shared by the allocator
`ifndef DYNAMIC_PARTITION_ALLOCATOR_ASSERT_SVH
`define DYNAMIC_PARTITION_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DPA_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DPA_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dpa_pkg.sv =====
package dpa_pkg;

    localparam int ADDR_W = 12;
    localparam int SIZE_W = 13;

    localparam logic [SIZE_W-1:0] STORE_BYTES   = 13'd4096;
    localparam logic [SIZE_W-1:0] STORE_MIN     = 13'd2;
    localparam logic [31:0]       NEVER_STAMP   = 32'hFFFF_FFFF;
    localparam logic [31:0]       STAMP_TOP     = 32'hFFFF_FFFE;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    localparam logic STATUS_STORED   = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef enum logic [1:0] {
        REG_STORE_SIZE = 2'd0,
        REG_MIN_SIZE   = 2'd1,
        REG_FIT_MODE   = 2'd2,
        REG_EPC        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [12:0] request_size;
        logic [2:0]  queue_kind;
        logic [31:0] message_id;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [11:0] first_address;
        logic [11:0] last_address;
        logic [7:0]  evictions_done;
        logic [3:0]  compactions_done;
    } rsp_t;

    // settings seen by the sequencer
    typedef struct packed {
        logic [SIZE_W-1:0] store_size;
        logic [SIZE_W-1:0] min_size;
        logic              fit_mode;
        logic [6:0]        epc;
        logic              reinit;
    } cfg_t;

    // one partition table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [2:0]        kind;
        logic [31:0]       msg_id;
        logic [31:0]       age;
    } entry_t;

endpackage

// ===== hdl/dpa_cfg.sv =====
module dpa_cfg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output dpa_pkg::cfg_t cfg
);
    import dpa_pkg::*;

    logic [SIZE_W-1:0] store_size_reg;
    logic [SIZE_W-1:0] min_size_reg;
    logic              fit_mode_reg;
    logic [6:0]        epc_reg;
    logic [SIZE_W-1:0] ss_wdata;
    logic              wr;
    reg_idx_t          idx;

    assign wr     = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;

    // store size is saturated into its legal range
    always_comb
    begin
        ss_wdata = pwdata[SIZE_W-1:0];
        if (ss_wdata < STORE_MIN)
            ss_wdata = STORE_MIN;
        else if (ss_wdata > STORE_BYTES)
            ss_wdata = STORE_BYTES;
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_size_reg <= STORE_BYTES;
            min_size_reg   <= 13'd16;
            fit_mode_reg   <= FIT_FIRST;
            epc_reg        <= 7'd4;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_STORE_SIZE: store_size_reg <= ss_wdata;
                REG_MIN_SIZE:   min_size_reg   <= pwdata[SIZE_W-1:0];
                REG_FIT_MODE:   fit_mode_reg   <= pwdata[0];
                REG_EPC:        epc_reg        <= pwdata[6:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_STORE_SIZE: prdata = {19'd0, store_size_reg};
            REG_MIN_SIZE:   prdata = {19'd0, min_size_reg};
            REG_FIT_MODE:   prdata = {31'd0, fit_mode_reg};
            REG_EPC:        prdata = {25'd0, epc_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // zero-valued limits act as one
    assign cfg.store_size = store_size_reg;
    assign cfg.min_size   = (min_size_reg == '0) ? 13'd1 : min_size_reg;
    assign cfg.fit_mode   = fit_mode_reg;
    assign cfg.epc        = (epc_reg == '0) ? 7'd1 : epc_reg;
    assign cfg.reinit     = wr && (idx == REG_STORE_SIZE);

endmodule

// ===== hdl/dpa_ctrl.sv =====
module dpa_ctrl
#(
    parameter int TABLE_ENTRIES = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  dpa_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_stall,
    input  dpa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dpa_pkg::rsp_t rsp
);
    import dpa_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW:0] LAST_CNT = (IW+1)'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FIND, S_PLACE, S_SPLIT, S_MERGE, S_MERGE_WR,
        S_CDROP, S_CSCAN, S_CWR, S_CTAIL, S_DONE
    } state_t;

    state_t            state_reg;
    entry_t            mem [TABLE_ENTRIES];
    entry_t            rd_data_reg;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    entry_t            wr_data;

    logic [IW:0]       scan_cnt_reg;
    logic              rd_vld_reg;
    logic [IW-1:0]     rd_idx_reg;
    req_t              req_reg;
    logic [6:0]        k_reg;
    logic [7:0]        evs_reg;
    logic [3:0]        comps_reg;
    logic [31:0]       stamp_reg;
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] free_reg;
    logic [TABLE_ENTRIES-1:0] done_reg;

    logic              best_found_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [ADDR_W-1:0] best_start_reg;
    logic [ADDR_W-1:0] best_end_reg;
    logic [SIZE_W-1:0] best_waste_reg;
    logic              v_found_reg;
    logic [IW-1:0]     v_idx_reg;
    logic [ADDR_W-1:0] v_start_reg;
    logic [ADDR_W-1:0] v_end_reg;
    logic [31:0]       v_age_reg;
    logic              j_found_reg;
    logic [IW-1:0]     j_idx_reg;
    logic              l_found_reg;
    logic [IW-1:0]     l_idx_reg;
    logic [ADDR_W-1:0] l_start_reg;
    logic              r_found_reg;
    logic [IW-1:0]     r_idx_reg;
    logic [ADDR_W-1:0] r_end_reg;
    logic              p_found_reg;
    logic [IW-1:0]     p_idx_reg;
    entry_t            p_word_reg;
    logic [SIZE_W-1:0] c_addr_reg;
    rsp_t              res_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    logic              scanning;
    logic              scan_done;
    logic              d_used;
    logic              d_free;
    logic [SIZE_W-1:0] d_size;
    logic [SIZE_W-1:0] d_waste;
    logic              fit_hit;
    logic              vic_hit;
    logic              unused_hit;
    logic              l_hit;
    logic              r_hit;
    logic              pick_hit;
    logic              split;
    logic [SIZE_W-1:0] p_size;
    logic [SIZE_W-1:0] ss_last;
    logic              reject;
    logic              tail;

    // partition table: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[scan_cnt_reg[IW-1:0]];
    end

    assign scanning  = (state_reg == S_FIND) || (state_reg == S_MERGE) ||
                       (state_reg == S_CSCAN);
    assign scan_done = (scan_cnt_reg == LAST_CNT) && !rd_vld_reg;
    assign ss_last   = cfg.store_size - 13'd1;
    assign reject    = (req.request_size >= cfg.store_size) ||
                       (req.request_size < cfg.min_size);

    // per-entry evaluation of the word read last cycle
    always_comb
    begin
        d_used  = used_reg[rd_idx_reg];
        d_free  = free_reg[rd_idx_reg];
        d_size  = {1'b0, rd_data_reg.end_addr} - {1'b0, rd_data_reg.start_addr} + 13'd1;
        d_waste = d_size - req_reg.request_size;
        fit_hit = rd_vld_reg && d_used && d_free && (d_size >= req_reg.request_size);
        if (fit_hit && best_found_reg)
        begin
            if (cfg.fit_mode == FIT_BEST)
                fit_hit = (d_waste < best_waste_reg) ||
                          ((d_waste == best_waste_reg) &&
                           (rd_data_reg.start_addr < best_start_reg));
            else
                fit_hit = rd_data_reg.start_addr < best_start_reg;
        end
        vic_hit = rd_vld_reg && d_used && !d_free &&
                  (!v_found_reg || (rd_data_reg.age < v_age_reg) ||
                   ((rd_data_reg.age == v_age_reg) &&
                    (rd_data_reg.start_addr < v_start_reg)));
        unused_hit = rd_vld_reg && !d_used && !j_found_reg;
        l_hit = rd_vld_reg && (rd_idx_reg != v_idx_reg) && d_used && d_free &&
                !l_found_reg && (v_start_reg != '0) &&
                (rd_data_reg.end_addr == v_start_reg - 12'd1);
        r_hit = rd_vld_reg && (rd_idx_reg != v_idx_reg) && d_used && d_free &&
                !r_found_reg && ({1'b0, v_end_reg} < ss_last) &&
                ({1'b0, rd_data_reg.start_addr} == {1'b0, v_end_reg} + 13'd1);
        pick_hit = rd_vld_reg && d_used && !done_reg[rd_idx_reg] &&
                   (!p_found_reg || (rd_data_reg.start_addr < p_word_reg.start_addr));
        split  = (best_waste_reg != '0) && j_found_reg;
        p_size = {1'b0, p_word_reg.end_addr} - {1'b0, p_word_reg.start_addr} + 13'd1;
        tail   = (c_addr_reg < cfg.store_size) && j_found_reg;
    end

    // table write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '{start_addr: '0, end_addr: ss_last[ADDR_W-1:0], kind: '0,
                    msg_id: '0, age: NEVER_STAMP};
        unique case (state_reg)
            S_INIT:
            begin
                wr_en = 1'b1;
            end
            S_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = best_idx_reg;
                wr_data.start_addr = best_start_reg;
                wr_data.end_addr   = split ?
                    12'({1'b0, best_start_reg} + req_reg.request_size - 13'd1) :
                    best_end_reg;
                wr_data.kind   = req_reg.queue_kind;
                wr_data.msg_id = req_reg.message_id;
                wr_data.age    = stamp_reg;
            end
            S_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = j_idx_reg;
                wr_data.start_addr = 12'({1'b0, best_start_reg} + req_reg.request_size);
                wr_data.end_addr   = best_end_reg;
            end
            S_MERGE_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = v_idx_reg;
                wr_data.start_addr = l_found_reg ? l_start_reg : v_start_reg;
                wr_data.end_addr   = r_found_reg ? r_end_reg : v_end_reg;
            end
            S_CWR:
            begin
                wr_en   = 1'b1;
                wr_addr = p_idx_reg;
                wr_data = p_word_reg;
                wr_data.start_addr = c_addr_reg[ADDR_W-1:0];
                wr_data.end_addr   = 12'(c_addr_reg + p_size - 13'd1);
            end
            S_CTAIL:
            begin
                wr_en   = tail;
                wr_addr = j_idx_reg;
                wr_data.start_addr = c_addr_reg[ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            req_reg        <= '0;
            k_reg          <= '0;
            evs_reg        <= '0;
            comps_reg      <= '0;
            stamp_reg      <= '0;
            used_reg       <= TABLE_ENTRIES'(1);
            free_reg       <= '1;
            done_reg       <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
            best_waste_reg <= '0;
            v_found_reg    <= 1'b0;
            v_idx_reg      <= '0;
            v_start_reg    <= '0;
            v_end_reg      <= '0;
            v_age_reg      <= '0;
            j_found_reg    <= 1'b0;
            j_idx_reg      <= '0;
            l_found_reg    <= 1'b0;
            l_idx_reg      <= '0;
            l_start_reg    <= '0;
            r_found_reg    <= 1'b0;
            r_idx_reg      <= '0;
            r_end_reg      <= '0;
            p_found_reg    <= 1'b0;
            p_idx_reg      <= '0;
            p_word_reg     <= '0;
            c_addr_reg     <= '0;
            res_reg        <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            // scan engine: one table read per cycle
            rd_vld_reg <= 1'b0;
            if (scanning && (scan_cnt_reg != LAST_CNT))
            begin
                rd_vld_reg   <= 1'b1;
                rd_idx_reg   <= scan_cnt_reg[IW-1:0];
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end

            unique case (state_reg)
                S_INIT:
                begin
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cfg.reinit)
                    begin
                        used_reg  <= TABLE_ENTRIES'(1);
                        free_reg  <= '1;
                        state_reg <= S_INIT;
                    end
                    else if (req_valid)
                    begin
                        req_reg <= req;
                        if (reject)
                        begin
                            res_reg   <= '{status: STATUS_REJECTED, default: '0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            k_reg          <= '0;
                            evs_reg        <= '0;
                            comps_reg      <= '0;
                            scan_cnt_reg   <= '0;
                            best_found_reg <= 1'b0;
                            v_found_reg    <= 1'b0;
                            j_found_reg    <= 1'b0;
                            state_reg      <= S_FIND;
                        end
                    end
                end
                S_FIND:
                begin
                    if (fit_hit)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= rd_idx_reg;
                        best_start_reg <= rd_data_reg.start_addr;
                        best_end_reg   <= rd_data_reg.end_addr;
                        best_waste_reg <= d_waste;
                    end
                    if (vic_hit)
                    begin
                        v_found_reg <= 1'b1;
                        v_idx_reg   <= rd_idx_reg;
                        v_start_reg <= rd_data_reg.start_addr;
                        v_end_reg   <= rd_data_reg.end_addr;
                        v_age_reg   <= rd_data_reg.age;
                    end
                    if (unused_hit)
                    begin
                        j_found_reg <= 1'b1;
                        j_idx_reg   <= rd_idx_reg;
                    end
                    if (scan_done)
                    begin
                        if (best_found_reg)
                            state_reg <= S_PLACE;
                        else if (v_found_reg)
                        begin
                            scan_cnt_reg <= '0;
                            l_found_reg  <= 1'b0;
                            r_found_reg  <= 1'b0;
                            state_reg    <= S_MERGE;
                        end
                        else
                            state_reg <= S_CDROP;
                    end
                end
                S_PLACE:
                begin
                    free_reg[best_idx_reg] <= 1'b0;
                    if (stamp_reg < STAMP_TOP)
                        stamp_reg <= stamp_reg + 32'd1;
                    res_reg.status           <= STATUS_STORED;
                    res_reg.first_address    <= best_start_reg;
                    res_reg.last_address     <= wr_data.end_addr;
                    res_reg.evictions_done   <= evs_reg;
                    res_reg.compactions_done <= comps_reg;
                    state_reg <= split ? S_SPLIT : S_DONE;
                end
                S_SPLIT:
                begin
                    used_reg[j_idx_reg] <= 1'b1;
                    free_reg[j_idx_reg] <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_MERGE:
                begin
                    if (l_hit)
                    begin
                        l_found_reg <= 1'b1;
                        l_idx_reg   <= rd_idx_reg;
                        l_start_reg <= rd_data_reg.start_addr;
                    end
                    if (r_hit)
                    begin
                        r_found_reg <= 1'b1;
                        r_idx_reg   <= rd_idx_reg;
                        r_end_reg   <= rd_data_reg.end_addr;
                    end
                    if (scan_done)
                        state_reg <= S_MERGE_WR;
                end
                S_MERGE_WR:
                begin
                    free_reg[v_idx_reg] <= 1'b1;
                    if (l_found_reg)
                        used_reg[l_idx_reg] <= 1'b0;
                    if (r_found_reg)
                        used_reg[r_idx_reg] <= 1'b0;
                    if (evs_reg != 8'hFF)
                        evs_reg <= evs_reg + 8'd1;
                    k_reg <= k_reg + 7'd1;
                    if (7'(k_reg + 7'd1) == cfg.epc)
                        state_reg <= S_CDROP;
                    else
                    begin
                        scan_cnt_reg   <= '0;
                        best_found_reg <= 1'b0;
                        v_found_reg    <= 1'b0;
                        j_found_reg    <= 1'b0;
                        state_reg      <= S_FIND;
                    end
                end
                S_CDROP:
                begin
                    // free partitions vanish, occupied ones get repacked
                    used_reg     <= used_reg & ~free_reg;
                    done_reg     <= '0;
                    c_addr_reg   <= '0;
                    scan_cnt_reg <= '0;
                    p_found_reg  <= 1'b0;
                    j_found_reg  <= 1'b0;
                    state_reg    <= S_CSCAN;
                end
                S_CSCAN:
                begin
                    if (pick_hit)
                    begin
                        p_found_reg <= 1'b1;
                        p_idx_reg   <= rd_idx_reg;
                        p_word_reg  <= rd_data_reg;
                    end
                    if (unused_hit)
                    begin
                        j_found_reg <= 1'b1;
                        j_idx_reg   <= rd_idx_reg;
                    end
                    if (scan_done)
                        state_reg <= p_found_reg ? S_CWR : S_CTAIL;
                end
                S_CWR:
                begin
                    done_reg[p_idx_reg] <= 1'b1;
                    c_addr_reg   <= c_addr_reg + p_size;
                    scan_cnt_reg <= '0;
                    p_found_reg  <= 1'b0;
                    j_found_reg  <= 1'b0;
                    state_reg    <= S_CSCAN;
                end
                S_CTAIL:
                begin
                    if (tail)
                    begin
                        used_reg[j_idx_reg] <= 1'b1;
                        free_reg[j_idx_reg] <= 1'b1;
                    end
                    if (comps_reg != 4'hF)
                        comps_reg <= comps_reg + 4'd1;
                    k_reg          <= '0;
                    scan_cnt_reg   <= '0;
                    best_found_reg <= 1'b0;
                    v_found_reg    <= 1'b0;
                    j_found_reg    <= 1'b0;
                    state_reg      <= S_FIND;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/dynamic_partition_allocator.sv =====
// from acceptance to result valid: a rejected request goes straight to the result; a placement
// scans all N = TABLE_ENTRIES entries (one table read a cycle), places, and splits if needed
// each eviction adds a merge scan and merge write, plus a new search unless compaction follows
// each compaction adds a scan and move per occupied partition, a last scan and tail write, then a search
// one transaction in flight; the next is taken the cycle after the result is registered
// reset: the table init state writes entry 0, request input stalled meanwhile
module dynamic_partition_allocator
#(
    parameter int TABLE_ENTRIES = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          req_valid,
    output logic          req_stall,
    input  dpa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dpa_pkg::rsp_t rsp
);
    import dpa_pkg::*;

`include "dynamic_partition_allocator_assert.svh"

    cfg_t cfg;

    // register file
    dpa_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // table sequencer
    dpa_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // checks
    `DPA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request not held off")
    `DPA_ASSERT_NOW(a_place_order, rsp_valid && (rsp.status == STATUS_STORED), rsp.first_address <= rsp.last_address, "inverted placement")
    `DPA_ASSERT_NOW(a_reject_zero, rsp_valid && (rsp.status == STATUS_REJECTED), (rsp.first_address == '0) && (rsp.last_address == '0) && (rsp.evictions_done == '0) && (rsp.compactions_done == '0), "rejected result not cleared")

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpa_pkg::*;

    localparam int NENT = 32;
    localparam int WATCHDOG_LIMIT = 400000;

    // ---------------------------------------------------------------
    // predictor of the partition table
    class partition_scoreboard;
        bit          slot_used [NENT];
        bit          slot_free [NENT];
        int unsigned slot_lo [NENT];
        int unsigned slot_hi [NENT];
        int unsigned slot_age [NENT];
        int unsigned stamp;
        int unsigned store_bytes;
        int unsigned min_bytes;
        bit          least_waste;
        int unsigned evict_quota;
        rsp_t        pending [$];
        int          errors;

        function new();
            errors = 0;
            stamp = 0;
            store_bytes = 4096;
            min_bytes = 16;
            least_waste = 0;
            evict_quota = 4;
            clear_table();
        endfunction

        function void clear_slot(int i);
            slot_used[i] = 0;
            slot_free[i] = 1;
            slot_lo[i] = 0;
            slot_hi[i] = 0;
            slot_age[i] = NEVER_STAMP;
        endfunction

        function void clear_table();
            for (int i = 0; i < NENT; i++)
                clear_slot(i);
            slot_used[0] = 1;
            slot_hi[0] = store_bytes - 1;
        endfunction

        function void write_reg(reg_idx_t idx, int unsigned value);
            int unsigned v;
            case (idx)
                REG_STORE_SIZE:
                begin
                    v = value & 13'h1FFF;
                    if (v < 2) v = 2;
                    if (v > 4096) v = 4096;
                    store_bytes = v;
                    clear_table();
                end
                REG_MIN_SIZE: min_bytes = value & 13'h1FFF;
                REG_FIT_MODE: least_waste = value & 1;
                REG_EPC:      evict_quota = value & 7'h7F;
                default: ;
            endcase
        endfunction

        function int spare_slot();
            for (int i = 0; i < NENT; i++)
                if (!slot_used[i]) return i;
            return -1;
        endfunction

        function int unsigned span(int i);
            return slot_hi[i] - slot_lo[i] + 1;
        endfunction

        function int pick_hole(int unsigned want);
            int b;
            int unsigned wi, wb;
            b = -1;
            for (int i = 0; i < NENT; i++)
            begin
                if (!slot_used[i] || !slot_free[i] || span(i) < want) continue;
                if (b < 0) b = i;
                else if (!least_waste)
                begin
                    if (slot_lo[i] < slot_lo[b]) b = i;
                end
                else
                begin
                    wi = span(i) - want;
                    wb = span(b) - want;
                    if (wi < wb || (wi == wb && slot_lo[i] < slot_lo[b])) b = i;
                end
            end
            return b;
        endfunction

        function bit evict_oldest();
            int v;
            v = -1;
            for (int i = 0; i < NENT; i++)
            begin
                if (!slot_used[i] || slot_free[i]) continue;
                if (v < 0 || slot_age[i] < slot_age[v] ||
                    (slot_age[i] == slot_age[v] && slot_lo[i] < slot_lo[v]))
                    v = i;
            end
            if (v < 0) return 0;
            slot_free[v] = 1;
            slot_age[v] = NEVER_STAMP;
            // merge with free neighbor below, then above
            if (slot_lo[v] > 0)
                for (int i = 0; i < NENT; i++)
                    if (i != v && slot_used[i] && slot_free[i] && slot_hi[i] == slot_lo[v] - 1)
                    begin
                        slot_lo[v] = slot_lo[i];
                        clear_slot(i);
                        break;
                    end
            if (slot_hi[v] < store_bytes - 1)
                for (int i = 0; i < NENT; i++)
                    if (i != v && slot_used[i] && slot_free[i] && slot_lo[i] == slot_hi[v] + 1)
                    begin
                        slot_hi[v] = slot_hi[i];
                        clear_slot(i);
                        break;
                    end
            return 1;
        endfunction

        function void compact_table();
            bit          moved [NENT];
            int unsigned addr;
            int unsigned sz;
            int          p, j;
            addr = 0;
            for (int i = 0; i < NENT; i++)
            begin
                if (slot_used[i] && slot_free[i]) clear_slot(i);
                moved[i] = 0;
            end
            forever
            begin
                p = -1;
                for (int i = 0; i < NENT; i++)
                    if (slot_used[i] && !moved[i] && (p < 0 || slot_lo[i] < slot_lo[p]))
                        p = i;
                if (p < 0) break;
                sz = span(p);
                slot_lo[p] = addr;
                slot_hi[p] = addr + sz - 1;
                addr += sz;
                moved[p] = 1;
            end
            if (addr < store_bytes)
            begin
                j = spare_slot();
                if (j >= 0)
                begin
                    slot_used[j] = 1;
                    slot_free[j] = 1;
                    slot_lo[j] = addr;
                    slot_hi[j] = store_bytes - 1;
                end
            end
        endfunction

        // note an accepted request and queue its placement
        function void note_request(req_t r);
            rsp_t        e;
            int unsigned want, mn, quota, evs, comps, k;
            int          s, j;
            want = r.request_size;
            mn = (min_bytes < 1) ? 1 : min_bytes;
            quota = (evict_quota < 1) ? 1 : evict_quota;
            evs = 0;
            comps = 0;
            s = -1;
            e = '0;
            if (want >= store_bytes || want < mn)
            begin
                e.status = STATUS_REJECTED;
                pending.push_back(e);
                return;
            end
            forever
            begin
                k = 0;
                while (k < quota)
                begin
                    s = pick_hole(want);
                    if (s >= 0) break;
                    if (!evict_oldest()) break;
                    if (evs < 255) evs++;
                    k++;
                end
                if (s >= 0) break;
                compact_table();
                if (comps < 15) comps++;
            end
            // occupy from the start, split off the rest if a slot is spare
            if (span(s) > want)
            begin
                j = spare_slot();
                if (j >= 0)
                begin
                    slot_used[j] = 1;
                    slot_free[j] = 1;
                    slot_lo[j] = slot_lo[s] + want;
                    slot_hi[j] = slot_hi[s];
                    slot_hi[s] = slot_lo[s] + want - 1;
                end
            end
            slot_free[s] = 0;
            slot_age[s] = stamp;
            if (stamp < STAMP_TOP) stamp++;
            e.status = STATUS_STORED;
            e.first_address = slot_lo[s][11:0];
            e.last_address = slot_hi[s][11:0];
            e.evictions_done = evs[7:0];
            e.compactions_done = comps[3:0];
            pending.push_back(e);
        endfunction

        function void check_placement(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected placement result %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.first_address !== e.first_address)
            begin
                $error("first_address: expected %0d actual %0d", e.first_address,
                       got.first_address);
                errors++;
            end
            if (got.last_address !== e.last_address)
            begin
                $error("last_address: expected %0d actual %0d", e.last_address,
                       got.last_address);
                errors++;
            end
            if (got.evictions_done !== e.evictions_done)
            begin
                $error("evictions_done: expected %0d actual %0d", e.evictions_done,
                       got.evictions_done);
                errors++;
            end
            if (got.compactions_done !== e.compactions_done)
            begin
                $error("compactions_done: expected %0d actual %0d", e.compactions_done,
                       got.compactions_done);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;

    partition_scoreboard sb;
    int  accepted_count;
    int  idle_cycles;
    bit  hold_rsp;
    bit  stim_done;

    dynamic_partition_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall, plus a long hold-off when asked
    initial
    begin
        int wait_n;
        rsp_stall = 1;
        @(posedge clk iff rst_n);
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 1)) wait_n = 0;
            if (wait_n > 0 || hold_rsp)
            begin
                rsp_stall <= 1;
                repeat (wait_n) @(posedge clk);
                while (hold_rsp) @(posedge clk);
            end
            rsp_stall <= 0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            sb.check_placement(rsp);
        end
    end

    task automatic reg_write(reg_idx_t idx, int unsigned value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 4'(int'(idx) * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic send_request(int unsigned sz, int unsigned kind, int unsigned id, bit gaps);
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 12) : 0;
        if (gaps && $urandom_range(0, 2) == 0) wait_n = 0;
        if (wait_n > 0)
        begin
            req_valid <= 0;
            repeat (wait_n) @(posedge clk);
        end
        req_valid <= 1;
        req.request_size <= sz[12:0];
        req.queue_kind <= kind[2:0];
        req.message_id <= id;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request('{sz[12:0], kind[2:0], id});
        accepted_count++;
    endtask

    // idle the request side, drain results, then let the block settle
    task automatic drain();
        req_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // sizes mostly small so that the table fills and evictions happen
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 300);
        if (r < 90) return $urandom_range(300, 1500);
        if (r < 96) return $urandom_range(1500, 4096);
        return $urandom_range(4096, 8191);
    endfunction

    initial
    begin
        int unsigned sizes [$];
        int          n;
        sb = new();
        accepted_count = 0;
        idle_cycles = 0;
        hold_rsp = 0;
        stim_done = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req_valid = 0;
        req = '0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, both fit modes, rejects, forced evictions
        sizes = '{0, 1, 15, 16, 4095, 4096, 8191, 2048, 1024, 1024, 512, 4000};
        foreach (sizes[i])
            send_request(sizes[i], i % 8, (i % 2) ? 32'hFFFF_FFFF : 32'h0, 0);
        drain();
        reg_write(REG_MIN_SIZE, 1);
        reg_write(REG_FIT_MODE, FIT_BEST);
        reg_write(REG_EPC, 1);
        sizes = '{1, 3000, 100, 50, 1000, 60, 2500, 4095, 1, 7};
        foreach (sizes[i])
            send_request(sizes[i], 7 - i % 8, $urandom, 0);
        drain();
        // tiny store: single-byte partitions fill the two-byte store, a two-byte request is rejected
        reg_write(REG_STORE_SIZE, 2);
        send_request(1, 1, 1, 0);
        send_request(2, 2, 2, 0);
        send_request(1, 3, 3, 0);
        drain();

        // random phases over several settings
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin reg_write(REG_STORE_SIZE, 4096); reg_write(REG_MIN_SIZE, 16);
                         reg_write(REG_FIT_MODE, FIT_FIRST); reg_write(REG_EPC, 4); end
                1: begin reg_write(REG_FIT_MODE, FIT_BEST); reg_write(REG_EPC, 64); end
                2: begin reg_write(REG_STORE_SIZE, 600); reg_write(REG_MIN_SIZE, 1);
                         reg_write(REG_EPC, 1); end
                3: begin reg_write(REG_STORE_SIZE, 0); reg_write(REG_MIN_SIZE, 0);
                         reg_write(REG_EPC, 0); end
                4: begin reg_write(REG_STORE_SIZE, 8191); reg_write(REG_MIN_SIZE, 4096);
                         reg_write(REG_FIT_MODE, FIT_FIRST); end
                5: begin reg_write(REG_MIN_SIZE, 2); reg_write(REG_EPC, 127);
                         reg_write(REG_STORE_SIZE, 1000); end
                6: begin reg_write(REG_STORE_SIZE, 4096); reg_write(REG_EPC, 2);
                         reg_write(REG_FIT_MODE, FIT_BEST); end
                default: begin reg_write(REG_MIN_SIZE, 8191); reg_write(REG_EPC, 3); end
            endcase
            n = (phase == 7) ? 60 : 230;
            if (phase == 1)
            begin
                // long result hold-off while requests keep coming
                fork
                    begin
                        hold_rsp = 1;
                        repeat (600) @(posedge clk);
                        hold_rsp = 0;
                    end
                join_none
            end
            for (int i = 0; i < n; i++)
            begin
                if (phase == 3 && $urandom_range(0, 1))
                    send_request($urandom_range(0, 3), $urandom_range(0, 7), $urandom,
                                 $urandom_range(0, 3) != 0);
                else
                    send_request(pick_size(), $urandom_range(0, 7), $urandom,
                                 (i % 64) >= 16);
            end
            drain();
        end
        stim_done = 1;

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
